// ===== src/groc_pkg.sv =====
package groc_pkg;

	localparam int CW = 7;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_REMOVE,
		OP_MOVE,
		OP_QUERY
	} op_t;

	typedef enum logic {
		REG_GRID_WIDTH,
		REG_GRID_HEIGHT
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DECIDE,
		ST_CHECK,
		ST_SLOT,
		ST_ERASE,
		ST_PAINT,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		LD_NONE,
		LD_NEW,
		LD_OLD
	} loop_ld_t;

	typedef struct packed {
		logic rd;
		logic wr;
		logic set_valid;
		logic clr_valid;
		logic slot_clr;
		logic slot_step;
	} tbl_cmd_t;

	typedef struct packed {
		logic found;
		logic last;
	} slot_stat_t;

	typedef struct packed {
		logic [4:0] col;
		logic [4:0] row;
		logic [4:0] w;
		logic [4:0] h;
	} entry_t;

	// p lies in [s, s + n)
	function automatic logic in_span(logic [CW-1:0] p, logic [4:0] s, logic [4:0] n);
		logic [CW-1:0] lo;
		lo = {2'b00, s};
		return (p >= lo) && (p < (lo + {2'b00, n}));
	endfunction

	// [s, s + n) ends at or below lim
	function automatic logic fits_span(logic [4:0] s, logic [4:0] n, logic [CW-1:0] lim);
		return ({2'b00, s} + {2'b00, n}) <= lim;
	endfunction

endpackage

// ===== src/groc_row_unit.sv =====
module groc_row_unit import groc_pkg::*; #(
	parameter int NCOLS = 16
) (
	input  logic [NCOLS-1:0] occ,
	input  logic [4:0]       col,
	input  logic [4:0]       wid,
	input  logic             self_en,
	input  logic [4:0]       self_col,
	input  logic [4:0]       self_wid,
	output logic [NCOLS-1:0] mask,
	output logic             conflict
);

	logic [NCOLS-1:0] smask;

	always_comb begin
		for (int c = 0; c < NCOLS; c++) begin
			mask[c]  = in_span(CW'(c), col, wid);
			smask[c] = self_en && in_span(CW'(c), self_col, self_wid);
		end
		conflict = |(occ & mask & ~smask);
	end

endmodule

// ===== src/groc_item_table.sv =====
module groc_item_table import groc_pkg::*; #(
	parameter int MAX_ITEMS = 64,
	parameter int ITEM_AW   = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tbl_cmd_t           cmd,
	input  logic [ITEM_AW-1:0] idx,
	input  entry_t             wdata,
	output entry_t             rdata,
	output logic               valid_bit,
	output slot_stat_t         slot,
	output logic [ITEM_AW-1:0] slot_id
);

	localparam int NCH = (MAX_ITEMS + 7) / 8;
	localparam int CHW = (NCH > 1) ? $clog2(NCH) : 1;

	entry_t                 mem [MAX_ITEMS];
	entry_t                 rd_q;
	logic [MAX_ITEMS-1:0]   valid_q;
	logic [CHW-1:0]         ch_q;
	logic [NCH*8-1:0]       padded;
	logic [7:0]             chunk;
	logic [2:0]             pos;

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[idx] <= wdata;
		end
		if (cmd.rd) begin
			rd_q <= mem[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ch_q    <= '0;
		end else begin
			if (cmd.set_valid) begin
				valid_q[idx] <= 1'b1;
			end else if (cmd.clr_valid) begin
				valid_q[idx] <= 1'b0;
			end
			if (cmd.slot_clr) begin
				ch_q <= '0;
			end else if (cmd.slot_step) begin
				ch_q <= ch_q + CHW'(1);
			end
		end
	end

	// scan eight slots per cycle for the lowest free one
	always_comb begin
		padded = '1;
		padded[MAX_ITEMS-1:0] = valid_q;
		chunk = padded[{ch_q, 3'b000} +: 8];
		pos = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (!chunk[i]) begin
				pos = 3'(i);
			end
		end
		slot.found = ~&chunk;
		slot.last  = (ch_q == CHW'(NCH - 1));
		slot_id    = ITEM_AW'({ch_q, pos});
	end

	assign rdata     = rd_q;
	assign valid_bit = valid_q[idx];

endmodule

// ===== src/grid_rectangle_occupancy_map.sv =====
// Sequence: each request is loaded and decided; a query then reports; a remove erases
//   the item's rows; a move checks the new rows, erases the old rows and paints the new
//   ones; an add checks rows, scans at most ceil(MAX_ITEMS/8) slot groups and paints.
// Throughput: one request at a time; the next transfer can share the result's cycle.
// Reset: asynchronous, clears all cell occupancy and item valid bits, sets grid
//   size registers to 16 and empties the output register; no clearing pass.
module grid_rectangle_occupancy_map import groc_pkg::*; #(
	parameter int MAX_COLS  = 16,
	parameter int MAX_ROWS  = 16,
	parameter int MAX_ITEMS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// op[1:0], item_id[7:2], pos_x[12:8], pos_y[17:13], size_w[22:18], size_h[27:23]
	input  logic [31:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// ok[0], result_id[6:1]
	output logic [7:0]  m_axis_tdata,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data
);

	localparam int COL_AW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ROW_AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int ITEM_AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam logic [CW-1:0] MAXC = CW'(MAX_COLS);
	localparam logic [CW-1:0] MAXR = CW'(MAX_ROWS);

	state_t state_q, state_d;

	op_t          op_q;
	logic [5:0]   id_q;
	logic [4:0]   x_q, y_q, w_q, h_q;
	logic [5:0]   cur_row_q;
	logic [4:0]   cnt_q, rc_q, rw_q;
	logic [ITEM_AW-1:0] new_id_q;
	logic         res_ok_q;
	logic [5:0]   res_id_q;
	logic         m_valid_q;
	logic [7:0]   m_data_q;
	logic [4:0]   gw_q, gh_q;

	logic [MAX_COLS-1:0] occ_q [MAX_ROWS];
	logic [ITEM_AW-1:0]  own_mem [MAX_ROWS][MAX_COLS];
	logic [ITEM_AW-1:0]  own_rd_q [MAX_COLS];

	tbl_cmd_t     tbl_cmd;
	entry_t       ent, tbl_wdata;
	logic         tbl_valid;
	slot_stat_t   slot;
	logic [ITEM_AW-1:0] slot_id, tbl_idx;

	logic [CW-1:0] used_cols, used_rows;
	logic [4:0]    sz_w, sz_h;
	logic          inb_new, id_ok, q_hit, row_last, self_row, conflict;
	logic [MAX_COLS-1:0] row_mask, occ_row;
	logic [5:0]    q_id;
	logic          s_xfer, out_free;

	loop_ld_t      loop_ld;
	logic          loop_step, occ_we, occ_set, own_we, own_rd, res_clr, res_set;
	logic          res_ok_v, new_id_ld, out_ld, self_en;
	logic [5:0]    res_id_v;

	assign s_xfer   = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;

	always_comb begin
		used_cols = ({2'b00, gw_q} > MAXC) ? MAXC : {2'b00, gw_q};
		used_rows = ({2'b00, gh_q} > MAXR) ? MAXR : {2'b00, gh_q};
		sz_w      = (op_q == OP_ADD) ? w_q : ent.w;
		sz_h      = (op_q == OP_ADD) ? h_q : ent.h;
		inb_new   = fits_span(x_q, sz_w, used_cols) && fits_span(y_q, sz_h, used_rows);
		id_ok     = ({3'b000, id_q} < 9'(MAX_ITEMS)) && tbl_valid;
		q_hit     = ({2'b00, x_q} < used_cols) && ({2'b00, y_q} < used_rows)
			&& occ_q[ROW_AW'(y_q)][COL_AW'(x_q)];
		q_id      = 6'(own_rd_q[COL_AW'(x_q)]);
		row_last  = (cnt_q == 5'd1);
		self_row  = in_span({1'b0, cur_row_q}, ent.row, ent.h);
		occ_row   = occ_q[ROW_AW'(cur_row_q)];
		tbl_idx   = (op_q == OP_ADD) ? new_id_q : ITEM_AW'(id_q);
		tbl_wdata = '{col: x_q, row: y_q, w: sz_w, h: sz_h};
	end

	groc_row_unit #(
		.NCOLS (MAX_COLS)
	) u_row (
		.occ      (occ_row),
		.col      (rc_q),
		.wid      (rw_q),
		.self_en  (self_en),
		.self_col (ent.col),
		.self_wid (ent.w),
		.mask     (row_mask),
		.conflict (conflict)
	);

	groc_item_table #(
		.MAX_ITEMS (MAX_ITEMS),
		.ITEM_AW   (ITEM_AW)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (tbl_cmd),
		.idx       (tbl_idx),
		.wdata     (tbl_wdata),
		.rdata     (ent),
		.valid_bit (tbl_valid),
		.slot      (slot),
		.slot_id   (slot_id)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: state_d = ST_DECIDE;
			ST_DECIDE: begin
				unique case (op_q)
					OP_ADD:    state_d = inb_new ? ST_CHECK : ST_DONE;
					OP_REMOVE: state_d = id_ok ? ST_ERASE : ST_DONE;
					OP_MOVE:   state_d = (id_ok && inb_new) ? ST_CHECK : ST_DONE;
					OP_QUERY:  state_d = ST_DONE;
				endcase
			end
			ST_CHECK: begin
				priority if (conflict) begin
					state_d = ST_DONE;
				end else if (row_last) begin
					state_d = (op_q == OP_ADD) ? ST_SLOT : ST_ERASE;
				end
			end
			ST_SLOT: begin
				priority if (slot.found) begin
					state_d = ST_PAINT;
				end else if (slot.last) begin
					state_d = ST_DONE;
				end
			end
			ST_ERASE: begin
				if (row_last) begin
					state_d = (op_q == OP_REMOVE) ? ST_DONE : ST_PAINT;
				end
			end
			ST_PAINT: begin
				if (row_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		tbl_cmd   = '0;
		loop_ld   = LD_NONE;
		loop_step = 1'b0;
		occ_we    = 1'b0;
		occ_set   = 1'b0;
		own_we    = 1'b0;
		own_rd    = 1'b0;
		res_clr   = 1'b0;
		res_set   = 1'b0;
		res_ok_v  = 1'b0;
		res_id_v  = '0;
		new_id_ld = 1'b0;
		out_ld    = 1'b0;
		self_en   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready    = 1'b1;
				tbl_cmd.slot_clr = 1'b1;
			end
			ST_LOAD: begin
				tbl_cmd.rd = 1'b1;
				own_rd     = 1'b1;
				res_clr    = 1'b1;
			end
			ST_DECIDE: begin
				loop_ld = (op_q == OP_REMOVE) ? LD_OLD : LD_NEW;
				if (op_q == OP_QUERY) begin
					res_set  = 1'b1;
					res_ok_v = q_hit;
					res_id_v = q_hit ? q_id : '0;
				end
			end
			ST_CHECK: begin
				self_en = (op_q == OP_MOVE) && self_row;
				if (row_last) begin
					loop_ld = (op_q == OP_MOVE) ? LD_OLD : LD_NEW;
				end else begin
					loop_step = 1'b1;
				end
			end
			ST_SLOT: begin
				tbl_cmd.slot_step = !slot.found;
				new_id_ld         = slot.found;
			end
			ST_ERASE: begin
				occ_we = 1'b1;
				if (row_last) begin
					if (op_q == OP_REMOVE) begin
						tbl_cmd.clr_valid = 1'b1;
						res_set  = 1'b1;
						res_ok_v = 1'b1;
					end else begin
						loop_ld = LD_NEW;
					end
				end else begin
					loop_step = 1'b1;
				end
			end
			ST_PAINT: begin
				occ_we  = 1'b1;
				occ_set = 1'b1;
				own_we  = 1'b1;
				if (row_last) begin
					tbl_cmd.wr        = 1'b1;
					tbl_cmd.set_valid = (op_q == OP_ADD);
					res_set  = 1'b1;
					res_ok_v = 1'b1;
					res_id_v = (op_q == OP_ADD) ? 6'(new_id_q) : '0;
				end else begin
					loop_step = 1'b1;
				end
			end
			ST_DONE: out_ld = out_free;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
			gw_q      <= 5'd16;
			gh_q      <= 5'd16;
			for (int r = 0; r < MAX_ROWS; r++) begin
				occ_q[r] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (out_ld) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_GRID_WIDTH:  gw_q <= cfg_data;
					REG_GRID_HEIGHT: gh_q <= cfg_data;
				endcase
			end
			if (occ_we) begin
				occ_q[ROW_AW'(cur_row_q)] <= occ_set ? (occ_row | row_mask)
					: (occ_row & ~row_mask);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (own_we) begin
			for (int c = 0; c < MAX_COLS; c++) begin
				if (row_mask[c]) begin
					own_mem[ROW_AW'(cur_row_q)][c] <= tbl_idx;
				end
			end
		end
		if (own_rd) begin
			own_rd_q <= own_mem[ROW_AW'(y_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			op_q <= op_t'(s_axis_tdata[1:0]);
			id_q <= s_axis_tdata[7:2];
			x_q  <= s_axis_tdata[12:8];
			y_q  <= s_axis_tdata[17:13];
			w_q  <= (s_axis_tdata[22:18] == 5'd0) ? 5'd1 : s_axis_tdata[22:18];
			h_q  <= (s_axis_tdata[27:23] == 5'd0) ? 5'd1 : s_axis_tdata[27:23];
		end
		unique case (loop_ld)
			LD_NEW: begin
				cur_row_q <= {1'b0, y_q};
				cnt_q     <= sz_h;
				rc_q      <= x_q;
				rw_q      <= sz_w;
			end
			LD_OLD: begin
				cur_row_q <= {1'b0, ent.row};
				cnt_q     <= ent.h;
				rc_q      <= ent.col;
				rw_q      <= ent.w;
			end
			default: begin
				if (loop_step) begin
					cur_row_q <= cur_row_q + 6'd1;
					cnt_q     <= cnt_q - 5'd1;
				end
			end
		endcase
		if (new_id_ld) begin
			new_id_q <= slot_id;
		end
		if (res_clr) begin
			res_ok_q <= 1'b0;
			res_id_q <= '0;
		end else if (res_set) begin
			res_ok_q <= res_ok_v;
			res_id_q <= res_id_v;
		end
		if (out_ld) begin
			m_data_q <= {1'b0, res_id_q, res_ok_q};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule
